// ----- src/clcw_pkg.sv -----
// clcw_pkg: types and codes shared by the character lcd cursor writer
// modules, and the line address function used by the front. no dependencies.
`default_nettype none

package clcw_pkg;

    // operation codes of an input item
    typedef enum logic [2:0] {
        OP_CHAR = 3'd0,
        OP_CMD  = 3'd1,
        OP_GOTO = 3'd2,
        OP_SET  = 3'd3,
        OP_NEXT = 3'd4
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_LINES = 2'd0,
        CFG_MAX_CHARS = 2'd1,
        CFG_FOUR_BIT  = 2'd2
    } t_cfg_idx;

    // register select of a strobe
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam logic [7:0] NEWLINE_CODE  = 8'h0A;
    localparam logic [7:0] ADDR_LINE0    = 8'h80;
    localparam logic [7:0] ADDR_LINE1    = 8'hC0;
    localparam logic [7:0] ADDR_LINE2    = 8'h90;
    localparam logic [7:0] ADDR_LINE3    = 8'hD0;
    localparam logic [2:0] MAX_LINES_CAP = 3'd4;

    typedef struct packed {
        logic [2:0] max_lines;
        logic [5:0] max_chars;
        logic       four_bit;
    } t_cfg;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
    } t_byte;

    // one queue entry: the bytes caused by one item
    typedef struct packed {
        logic  two;
        t_byte first;
        t_byte second;
    } t_entry;

    function automatic logic [7:0] line_addr(input logic [1:0] line,
                                             input logic [2:0] max_lines,
                                             input logic [5:0] max_chars);
        logic [7:0] lo;
        logic [7:0] addr;
        lo = (max_lines > 3'd2) ? {4'd0, max_chars[3:0]} : 8'd0;
        unique case (line)
            2'd0:    addr = ADDR_LINE0;
            2'd1:    addr = ADDR_LINE1;
            2'd2:    addr = ADDR_LINE2 + lo;
            default: addr = ADDR_LINE3 + lo;
        endcase
        return addr;
    endfunction

endpackage

`default_nettype wire

// ----- src/clcw_if.sv -----
// channel interfaces of the character lcd cursor writer: item input,
// strobe output and configuration write. no dependencies.
`default_nettype none

interface clcw_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] byte_value;
    logic [7:0] line_number;
    logic [7:0] column;

    modport source (output valid, operation, byte_value, line_number, column,
                    input ready);
    modport sink   (input valid, operation, byte_value, line_number, column,
                    output ready);
endinterface

interface clcw_out_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [7:0] bus_lines;
    logic       last_strobe;

    modport source (output valid, register_select, bus_lines, last_strobe,
                    input ready);
    modport sink   (input valid, register_select, bus_lines, last_strobe,
                    output ready);
endinterface

interface clcw_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [5:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/clcw_front.sv -----
// clcw_front: accepts items, keeps the cursor and turns each item into
// zero, one or two bus bytes for the queue. depends on clcw_pkg, clcw_if.
`default_nettype none

module clcw_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    clcw_in_if.sink           i_in,
    input  clcw_pkg::t_cfg    i_cfg,
    input  wire               i_full,
    output logic              o_push,
    output clcw_pkg::t_entry  o_entry
);
    import clcw_pkg::*;

    logic [1:0] r_line, n_line;
    logic [7:0] r_col,  n_col;

    logic       accept;
    logic       push;
    logic [2:0] eff_lines;
    logic [2:0] nl_sum;
    logic [1:0] nl;
    logic [7:0] nl_addr;
    logic [7:0] tgt_addr;
    logic       ln_ok;
    logic       col_ok;
    logic       is_nl;
    logic       wrap;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && push;

    always_comb begin
        eff_lines = (i_cfg.max_lines > MAX_LINES_CAP) ? MAX_LINES_CAP : i_cfg.max_lines;
        nl_sum    = {1'b0, r_line} + 3'd1;
        nl        = (nl_sum >= eff_lines) ? 2'd0 : nl_sum[1:0];
        nl_addr   = line_addr(nl, i_cfg.max_lines, i_cfg.max_chars);
        tgt_addr  = line_addr(i_in.line_number[1:0], i_cfg.max_lines, i_cfg.max_chars);
        ln_ok     = i_in.line_number < {5'd0, eff_lines};
        col_ok    = i_in.column < {2'd0, i_cfg.max_chars};
        is_nl     = i_in.byte_value == NEWLINE_CODE;
        wrap      = (r_col >= {2'd0, i_cfg.max_chars}) || is_nl;

        n_line  = r_line;
        n_col   = r_col;
        push    = 1'b0;
        o_entry = '0;
        unique case (t_op'(i_in.operation))
            OP_CHAR: begin
                push = 1'b1;
                if (wrap) begin
                    o_entry.first = '{rs: RS_CMD, data: nl_addr};
                    n_line = nl;
                    n_col  = 8'd0;
                    if (!is_nl) begin
                        o_entry.two    = 1'b1;
                        o_entry.second = '{rs: RS_DATA, data: i_in.byte_value};
                        n_col          = 8'd1;
                    end
                end else begin
                    o_entry.first = '{rs: RS_DATA, data: i_in.byte_value};
                    n_col = r_col + 8'd1;
                end
            end
            OP_CMD: begin
                push = 1'b1;
                o_entry.first = '{rs: RS_CMD, data: i_in.byte_value};
            end
            OP_GOTO: begin
                if (ln_ok) begin
                    push   = 1'b1;
                    n_line = i_in.line_number[1:0];
                    n_col  = 8'd0;
                    o_entry.first = '{rs: RS_CMD, data: tgt_addr};
                end
            end
            OP_SET: begin
                if (ln_ok && col_ok) begin
                    push   = 1'b1;
                    n_line = i_in.line_number[1:0];
                    n_col  = i_in.column;
                    o_entry.first = '{rs: RS_CMD, data: tgt_addr + i_in.column};
                end
            end
            OP_NEXT: begin
                push   = 1'b1;
                n_line = nl;
                n_col  = 8'd0;
                o_entry.first = '{rs: RS_CMD, data: nl_addr};
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= 2'd0;
            r_col  <= 8'd0;
        end else if (accept) begin
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

endmodule

`default_nettype wire

// ----- src/clcw_queue.sv -----
// clcw_queue: short flop queue of byte entries between front and back.
// depends on clcw_pkg.
`default_nettype none

module clcw_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  clcw_pkg::t_entry  i_entry,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_valid,
    output clcw_pkg::t_entry  o_head
);
    import clcw_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/clcw_back.sv -----
// clcw_back: walks the head entry strobe by strobe into the output
// register, splitting bytes into nibbles in 4-bit mode. depends on clcw_pkg.
`default_nettype none

module clcw_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_four,
    input  wire               i_valid,
    input  clcw_pkg::t_entry  i_head,
    output logic              o_pop,
    clcw_out_if.source        o_out
);
    import clcw_pkg::*;

    logic [1:0] r_step;
    logic       r_valid;
    logic       r_rs;
    logic [7:0] r_bus;
    logic       r_last;

    logic       load;
    logic       byte_sel;
    t_byte      cur;
    logic [7:0] bus;
    logic [1:0] last_step;
    logic       is_last;

    always_comb begin
        load     = !r_valid || o_out.ready;
        byte_sel = i_four ? r_step[1] : r_step[0];
        cur      = byte_sel ? i_head.second : i_head.first;
        if (!i_four) begin
            bus = cur.data;
        end else if (r_step[0]) begin
            bus = {cur.data[3:0], 4'h0};
        end else begin
            bus = {cur.data[7:4], 4'h0};
        end
        if (i_four) begin
            last_step = i_head.two ? 2'd3 : 2'd1;
        end else begin
            last_step = i_head.two ? 2'd1 : 2'd0;
        end
        is_last = r_step == last_step;
        o_pop   = load && i_valid && is_last;
    end

    assign o_out.valid           = r_valid;
    assign o_out.register_select = r_rs;
    assign o_out.bus_lines       = r_bus;
    assign o_out.last_strobe     = r_last;

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_rs   <= cur.rs;
            r_bus  <= bus;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_step <= is_last ? 2'd0 : r_step + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/char_lcd_cursor_writer_core.sv -----
// char_lcd_cursor_writer_core: top level of the character lcd cursor
// writer. depends on clcw_pkg, clcw_if, clcw_front, clcw_queue, clcw_back.
`default_nettype none

// Character LCD cursor writer. Items on i_in (char, raw command, go to
// line, set cursor, next line) are taken one per cycle while the byte
// queue has room; the front updates the cursor line and column at once and
// queues the one or two bus bytes that the item causes. The back sends one
// strobe per cycle on o_out while o_out.ready is high: one strobe per byte in
// 8-bit mode, two per byte in 4-bit mode, and a wrapping character other
// than a newline is two bytes. Sustained rate is set by the strobe output.
// Items that emit nothing (out-of-range go-to or set-cursor, unused codes)
// are taken like other items but queue no bytes.
// Configuration on i_cfg is always ready and must only be written while idle.
module char_lcd_cursor_writer_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    clcw_in_if.sink     i_in,
    clcw_out_if.source  o_out,
    clcw_cfg_if.sink    i_cfg
);
    import clcw_pkg::*;

    // configuration registers
    logic [2:0] r_max_lines;
    logic [5:0] r_max_chars;
    logic       r_four_bit;
    t_cfg       cfg;

    // front to queue to back
    logic   push;
    t_entry push_entry;
    logic   q_full;
    logic   q_valid;
    t_entry q_head;
    logic   pop;

    assign i_cfg.ready = 1'b1;
    assign cfg = '{max_lines: r_max_lines, max_chars: r_max_chars,
                   four_bit: r_four_bit};

    // register write; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lines <= 3'd2;
            r_max_chars <= 6'd16;
            r_four_bit  <= 1'b1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_MAX_LINES: r_max_lines <= i_cfg.data[2:0];
                CFG_MAX_CHARS: r_max_chars <= i_cfg.data;
                CFG_FOUR_BIT:  r_four_bit  <= i_cfg.data[0];
                default: begin
                    r_max_lines <= r_max_lines;
                end
            endcase
        end
    end

    // classify items and track the cursor
    clcw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // decouples item acceptance from strobe output
    clcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // byte to strobe sequencing with registered output
    clcw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_four  (cfg.four_bit),
        .i_valid (q_valid),
        .i_head  (q_head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- src/clcw_checker.sv -----
// clcw_checker: port-level assertions for char_lcd_cursor_writer_core,
// bound to the top level. depends on clcw_pkg.
`default_nettype none

module clcw_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_cfg_valid,
    input wire       i_cfg_ready,
    input wire [1:0] i_cfg_index,
    input wire [5:0] i_cfg_data,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_out_rs,
    input wire [7:0] i_out_bus,
    input wire       i_out_last
);
    import clcw_pkg::*;

    logic r_four;
    logic r_half;
    logic out_xfer;

    assign out_xfer = i_out_valid && i_out_ready;

    // shadow of the mode and the nibble position on the bus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four <= 1'b1;
            r_half <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index == CFG_FOUR_BIT) begin
                r_four <= i_cfg_data[0];
            end
            if (out_xfer && r_four) begin
                r_half <= !r_half;
            end
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("strobe dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_rs) && $stable(i_out_bus) && $stable(i_out_last))
        else $error("strobe payload changed while stalled");

    a_low_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_four |-> i_out_bus[3:0] == 4'h0)
        else $error("low bus bits set in 4-bit mode");

    a_last_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_four && i_out_last |-> r_half)
        else $error("item ended on a high nibble");

endmodule

bind char_lcd_cursor_writer_core clcw_checker u_clcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_rs    (o_out.register_select),
    .i_out_bus   (o_out.bus_lines),
    .i_out_last  (o_out.last_strobe)
);

`default_nettype wire
